// File: sv/qte_pkg.sv
package qte_pkg;

    // Fixed point format and field widths.
    localparam int FRAC_BITS = 16;
    localparam int COEFF_W   = 32;
    localparam int TIME_W    = 24;
    localparam int NUM_COEFF = 6;
    localparam int CFG_IDX_W = 3;

    // Powers of t are never negative, so the signed word range leaves 31 magnitude bits.
    localparam int POW_W      = COEFF_W - 1;
    localparam int POW_PROD_W = POW_W + TIME_W;
    localparam int POW_STAGES = 4;
    localparam int MAX_POWER  = 5;

    // Term arithmetic: coefficient times power, then a small constant, then the shift.
    localparam int PROD_W   = COEFF_W + POW_W;
    localparam int KMUL_W   = 6;
    localparam int SCALED_W = PROD_W + KMUL_W;
    localparam int TERM_W   = SCALED_W - FRAC_BITS;
    localparam int SUM_W    = TERM_W + 3;
    localparam int NUM_SUMS = 3;

    // Products, scaled terms, partial sums and the output register.
    localparam int TERM_STAGES = 4;

    // Twelve terms: position c1p1..c5p5, velocity 2c2p1..5c5p4, acceleration 6c3p1..20c5p3.
    localparam int NUM_TERMS = 12;
    localparam int TERM_C [NUM_TERMS] = '{1, 2, 3, 4, 5, 2, 3, 4, 5, 3, 4, 5};
    localparam int TERM_P [NUM_TERMS] = '{1, 2, 3, 4, 5, 1, 2, 3, 4, 1, 2, 3};
    localparam logic [KMUL_W-1:0] TERM_K [NUM_TERMS] =
        '{6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd12, 6'd20};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_0 = 3'd0,
        REG_COEFF_1 = 3'd1,
        REG_COEFF_2 = 3'd2,
        REG_COEFF_3 = 3'd3,
        REG_COEFF_4 = 3'd4,
        REG_COEFF_5 = 3'd5
    } t_reg_idx;

    typedef logic [POW_W-1:0] t_pow;

    // Powers of one request as they fill in along the power pipeline.
    typedef struct packed {
        logic [TIME_W-1:0]          t;
        logic [MAX_POWER:1][POW_W-1:0] p;
        logic                       clip;
    } t_powers;

    typedef struct packed {
        t_pow p;
        logic clip;
    } t_pow_res;

    typedef struct packed {
        logic [COEFF_W-1:0] v;
        logic               clip;
    } t_sat_res;

    // Next power: floor(p * t / 2^FRAC_BITS), clipped to the largest positive word.
    function automatic t_pow_res pow_step(input t_pow p, input logic [TIME_W-1:0] t);
        logic [POW_PROD_W-1:0]           prod;
        logic [POW_PROD_W-FRAC_BITS-1:0] sh;
        t_pow_res                        res;
        prod = POW_PROD_W'(p) * POW_PROD_W'(t);
        sh   = prod[POW_PROD_W-1:FRAC_BITS];
        res.clip = |sh[POW_PROD_W-FRAC_BITS-1:POW_W];
        res.p    = res.clip ? '1 : sh[POW_W-1:0];
        return res;
    endfunction

    // Exact product of a signed coefficient and a non-negative power.
    function automatic logic signed [PROD_W-1:0] mul_cp(input logic signed [COEFF_W-1:0] c,
                                                        input t_pow p);
        logic signed [COEFF_W-1:0] pe;
        pe = $signed({1'b0, p});
        return PROD_W'(c) * PROD_W'(pe);
    endfunction

    // Scale by a small constant and shift right arithmetically, which rounds toward minus infinity.
    function automatic logic signed [TERM_W-1:0] scale_term(input logic signed [PROD_W-1:0] prod,
                                                            input logic [KMUL_W-1:0] k);
        logic signed [SCALED_W-1:0] s;
        logic signed [SCALED_W-1:0] kx;
        logic signed [SCALED_W-1:0] scaled;
        s      = SCALED_W'(prod);
        kx     = $signed(SCALED_W'(k));
        scaled = s * kx;
        return scaled[SCALED_W-1:FRAC_BITS];
    endfunction

    // Clip a sum to the signed output word.
    function automatic t_sat_res sat_out(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-COEFF_W:0] upper;
        t_sat_res               res;
        upper    = s[SUM_W-1:COEFF_W-1];
        res.clip = !((&upper) || !(|upper));
        if (!res.clip) begin
            res.v = s[COEFF_W-1:0];
        end else if (s[SUM_W-1]) begin
            res.v = {1'b1, {(COEFF_W-1){1'b0}}};
        end else begin
            res.v = {1'b0, {(COEFF_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// File: sv/qte_powers.sv
module qte_powers
    import qte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [TIME_W-1:0] i_time,
    output logic              o_stall,
    output logic              o_valid,
    output t_powers           o_pw,
    input  logic              i_stall
);

    logic [POW_STAGES-1:0] r_valid;
    logic [POW_STAGES-1:0] adv;
    logic [POW_STAGES-1:0] in_v;
    t_powers               r_pw [POW_STAGES];
    t_powers               n_pw [POW_STAGES];
    t_pow_res              res  [POW_STAGES];

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        adv[POW_STAGES-1] = !r_valid[POW_STAGES-1] || !i_stall;
        for (int k = POW_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
        in_v = {r_valid[POW_STAGES-2:0], i_valid};
    end

    // Each stage forms one more power from the one before it and t.
    always_comb begin
        res[0]         = pow_step(t_pow'(i_time), i_time);
        n_pw[0]        = '0;
        n_pw[0].t      = i_time;
        n_pw[0].p[1]   = t_pow'(i_time);
        n_pw[0].p[2]   = res[0].p;
        n_pw[0].clip   = res[0].clip;
        for (int k = 1; k < POW_STAGES; k++) begin
            res[k]           = pow_step(r_pw[k-1].p[k+1], r_pw[k-1].t);
            n_pw[k]          = r_pw[k-1];
            n_pw[k].p[k+2]   = res[k].p;
            n_pw[k].clip     = r_pw[k-1].clip | res[k].clip;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < POW_STAGES; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= in_v[k];
                end
            end
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < POW_STAGES; k++) begin
            if (adv[k] && in_v[k]) begin
                r_pw[k] <= n_pw[k];
            end
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_valid[POW_STAGES-1];
    assign o_pw    = r_pw[POW_STAGES-1];

endmodule

// File: sv/quintic_trajectory_evaluator_unit.sv
// Eight register stages: four for the powers of t, then products, scaling, partial sums and the
// saturating output register. The block takes one request per cycle when the output is not stalled.
// Reset (synchronous, active low) empties every stage and clears all coefficients to zero.
module quintic_trajectory_evaluator_unit
    import qte_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [TIME_W-1:0]         i_time_point,
    output logic                      o_stall,
    output logic                      o_valid,
    output logic signed [COEFF_W-1:0] o_position,
    output logic signed [COEFF_W-1:0] o_velocity,
    output logic signed [COEFF_W-1:0] o_acceleration,
    output logic                      o_saturated,
    input  logic                      i_stall,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [COEFF_W-1:0]        i_cfg_data
);

    logic signed [COEFF_W-1:0] r_coeff [NUM_COEFF];

    logic    pw_valid;
    logic    pw_stall;
    t_powers pw;

    logic [TERM_STAGES-1:0] r_valid;
    logic [TERM_STAGES-1:0] adv;

    logic signed [PROD_W-1:0] r_prod [NUM_TERMS];
    logic signed [PROD_W-1:0] n_prod [NUM_TERMS];
    logic                     r_e_clip;
    logic signed [TERM_W-1:0] r_term [NUM_TERMS];
    logic signed [TERM_W-1:0] n_term [NUM_TERMS];
    logic                     r_f_clip;
    logic signed [SUM_W-1:0]  r_sum_a [NUM_SUMS];
    logic signed [SUM_W-1:0]  r_sum_b [NUM_SUMS];
    logic signed [SUM_W-1:0]  n_sum_a [NUM_SUMS];
    logic signed [SUM_W-1:0]  n_sum_b [NUM_SUMS];
    logic                     r_g_clip;
    t_sat_res                 sat [NUM_SUMS];
    logic [COEFF_W-1:0]       r_pos;
    logic [COEFF_W-1:0]       r_vel;
    logic [COEFF_W-1:0]       r_acc;
    logic                     r_sat;

    // Coefficient registers; writes beyond the last coefficient are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFF; i++) begin
                r_coeff[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_COEFF_0: r_coeff[0] <= i_cfg_data;
                REG_COEFF_1: r_coeff[1] <= i_cfg_data;
                REG_COEFF_2: r_coeff[2] <= i_cfg_data;
                REG_COEFF_3: r_coeff[3] <= i_cfg_data;
                REG_COEFF_4: r_coeff[4] <= i_cfg_data;
                REG_COEFF_5: r_coeff[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Powers t^1..t^5.
    qte_powers u_powers (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_time  (i_time_point),
        .o_stall (o_stall),
        .o_valid (pw_valid),
        .o_pw    (pw),
        .i_stall (pw_stall)
    );

    // Stage advance chain for the term and sum stages.
    always_comb begin
        adv[TERM_STAGES-1] = !r_valid[TERM_STAGES-1] || !i_stall;
        for (int k = TERM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end
    assign pw_stall = !adv[0];

    // Coefficient-power products, then constant scaling with the fraction shift.
    always_comb begin
        for (int i = 0; i < NUM_TERMS; i++) begin
            n_prod[i] = mul_cp(r_coeff[TERM_C[i]], pw.p[TERM_P[i]]);
            n_term[i] = scale_term(r_prod[i], TERM_K[i]);
        end
    end

    // Partial sums: position, velocity, acceleration, each split in two halves.
    always_comb begin
        n_sum_a[0] = SUM_W'(r_coeff[0]) + SUM_W'(r_term[0]) + SUM_W'(r_term[1]);
        n_sum_b[0] = SUM_W'(r_term[2]) + SUM_W'(r_term[3]) + SUM_W'(r_term[4]);
        n_sum_a[1] = SUM_W'(r_coeff[1]) + SUM_W'(r_term[5]) + SUM_W'(r_term[6]);
        n_sum_b[1] = SUM_W'(r_term[7]) + SUM_W'(r_term[8]);
        n_sum_a[2] = (SUM_W'(r_coeff[2]) <<< 1) + SUM_W'(r_term[9]);
        n_sum_b[2] = SUM_W'(r_term[10]) + SUM_W'(r_term[11]);
        for (int j = 0; j < NUM_SUMS; j++) begin
            sat[j] = sat_out(r_sum_a[j] + r_sum_b[j]);
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) begin
                r_valid[0] <= pw_valid;
            end
            for (int k = 1; k < TERM_STAGES; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        if (adv[0] && pw_valid) begin
            r_prod   <= n_prod;
            r_e_clip <= pw.clip;
        end
        if (adv[1] && r_valid[0]) begin
            r_term   <= n_term;
            r_f_clip <= r_e_clip;
        end
        if (adv[2] && r_valid[1]) begin
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_g_clip <= r_f_clip;
        end
        if (adv[3] && r_valid[2]) begin
            r_pos <= sat[0].v;
            r_vel <= sat[1].v;
            r_acc <= sat[2].v;
            r_sat <= r_g_clip | sat[0].clip | sat[1].clip | sat[2].clip;
        end
    end

    assign o_valid        = r_valid[TERM_STAGES-1];
    assign o_position     = r_pos;
    assign o_velocity     = r_vel;
    assign o_acceleration = r_acc;
    assign o_saturated    = r_sat;

    // The block refuses a request only when every stage holds one.
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_valid))
        else $error("request refused while a stage is empty");

    // A request leaving the power pipeline lands in the product stage.
    a_enter_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pw_valid && adv[0] |=> r_valid[0])
        else $error("request lost entering the product stage");

    // A request in the sum stage reaches the output register when it moves.
    a_reach_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[2] && adv[2] |=> r_valid[3])
        else $error("request lost entering the output register");

    // A clipped power always shows in the flag of its result.
    a_clip_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[2] && adv[3] && r_g_clip |=> o_saturated)
        else $error("power clip missing from the saturated flag");

endmodule

// File: sim/quintic_trajectory_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register write ports of the trajectory evaluator,
// predicts position, velocity and acceleration for every accepted request and compares
// each accepted result with the oldest prediction.
module quintic_trajectory_checker
    import qte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_stall,
    input  logic [TIME_W-1:0]  i_time_point,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [COEFF_W-1:0] i_position,
    input  logic [COEFF_W-1:0] i_velocity,
    input  logic [COEFF_W-1:0] i_acceleration,
    input  logic               i_saturated,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEFF_W-1:0] i_cfg_data,
    output int                 o_error_count,
    output int                 o_pending
);

    localparam int ACC_BITS = 64;

    typedef struct {
        logic [TIME_W-1:0]  time_point;
        logic [COEFF_W-1:0] position;
        logic [COEFF_W-1:0] velocity;
        logic [COEFF_W-1:0] acceleration;
        logic               saturated;
    } t_motion;

    logic signed [COEFF_W-1:0] coeff_reg [NUM_COEFF];
    t_motion                   motion_q [$];
    int                        error_cnt = 0;
    logic                      clip_hit;

    // Clip to a signed range of the given width; any clip marks the request as saturated.
    function automatic logic signed [127:0] clip_to_bits(input logic signed [127:0] v,
                                                        input int bits);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (v > hi) begin
            clip_hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clip_hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // One term k*c*p, taken exactly and then floored by the fraction bits.
    function automatic logic signed [127:0] scaled_term(input int k,
                                                       input logic signed [127:0] c,
                                                       input logic signed [127:0] p);
        logic signed [127:0] kk;
        kk = 128'(k);
        return clip_to_bits((kk * c * p) >>> FRAC_BITS, ACC_BITS);
    endfunction

    // Evaluate the quintic and its two derivatives at one time point.
    function automatic t_motion predict_motion(input logic [TIME_W-1:0] t);
        logic signed [127:0] pw [1:MAX_POWER];
        logic signed [127:0] c [NUM_COEFF];
        logic signed [127:0] pos;
        logic signed [127:0] vel;
        logic signed [127:0] acc;
        t_motion             m;
        clip_hit = 1'b0;
        foreach (c[n]) c[n] = 128'(coeff_reg[n]);

        // Powers of t, each product floored and clipped to the word.
        pw[1] = 128'(t);
        for (int n = 2; n <= MAX_POWER; n++) begin
            pw[n] = clip_to_bits((pw[n-1] * pw[1]) >>> FRAC_BITS, COEFF_W);
        end

        pos = c[0];
        for (int n = 1; n <= MAX_POWER; n++) begin
            pos = clip_to_bits(pos + scaled_term(1, c[n], pw[n]), ACC_BITS);
        end

        vel = c[1];
        for (int n = 2; n <= MAX_POWER; n++) begin
            vel = clip_to_bits(vel + scaled_term(n, c[n], pw[n-1]), ACC_BITS);
        end

        acc = 128'sd2 * c[2];
        acc = clip_to_bits(acc + scaled_term(6, c[3], pw[1]), ACC_BITS);
        acc = clip_to_bits(acc + scaled_term(12, c[4], pw[2]), ACC_BITS);
        acc = clip_to_bits(acc + scaled_term(20, c[5], pw[3]), ACC_BITS);

        m.time_point   = t;
        m.position     = COEFF_W'(clip_to_bits(pos, COEFF_W));
        m.velocity     = COEFF_W'(clip_to_bits(vel, COEFF_W));
        m.acceleration = COEFF_W'(clip_to_bits(acc, COEFF_W));
        m.saturated    = clip_hit;
        return m;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        error_cnt++;
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] t,
                               input logic [COEFF_W-1:0] got, input logic [COEFF_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("t=0x%06h %s: got 0x%08h, expected 0x%08h",
                                      t, name, got, want));
        end
    endtask

    // Track register writes, queue predictions for requests, compare accepted results.
    always @(posedge i_clk) begin
        t_motion want;
        if (!i_rst_n) begin
            foreach (coeff_reg[n]) coeff_reg[n] = '0;
            motion_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (motion_q.size() == 0) begin
                    report_mismatch("result with no request waiting");
                end else begin
                    want = motion_q.pop_front();
                    check_field("position", want.time_point, i_position, want.position);
                    check_field("velocity", want.time_point, i_velocity, want.velocity);
                    check_field("acceleration", want.time_point, i_acceleration,
                                want.acceleration);
                    check_field("saturated", want.time_point, COEFF_W'(i_saturated),
                                COEFF_W'(want.saturated));
                end
            end
            if (i_req_valid && !i_req_stall) begin
                motion_q.push_back(predict_motion(i_time_point));
            end
            // Indexes past the last coefficient are ignored by the block.
            if (i_cfg_we && (i_cfg_index < NUM_COEFF)) begin
                coeff_reg[i_cfg_index] = i_cfg_data;
            end
        end
        o_pending     <= motion_q.size();
        o_error_count <= error_cnt;
    end

endmodule

// File: sim/quintic_trajectory_evaluator_unit_tb.sv
`timescale 1ns / 100ps

module quintic_trajectory_evaluator_unit_tb;
    import qte_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [COEFF_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COEFF_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [COEFF_W-1:0] WORD_ONE = 32'h0001_0000;

    localparam logic [TIME_W-1:0] T_MAX       = '1;
    localparam logic [TIME_W-1:0] T_ONE       = 24'h01_0000;
    localparam logic [TIME_W-1:0] T_CLIP_EDGE = 24'h08_0000;

    // Time points around one second and around the point where t^5 starts to clip.
    localparam logic [TIME_W-1:0] SHAPE_TIMES [10] = '{
        24'h00_0000, 24'h00_0001, 24'h00_8000, 24'h01_0000, 24'h01_8000,
        24'h02_0000, 24'h07_FFFF, 24'h08_0000, 24'h08_0001, 24'hAA_AAAA
    };

    typedef enum int {
        COEF_FULL,
        COEF_SMALL,
        COEF_EXTREME,
        COEF_MIXED
    } t_coef_style;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic [TIME_W-1:0]   req_time;
    logic                req_stall;
    logic                res_valid;
    logic signed [COEFF_W-1:0] res_position;
    logic signed [COEFF_W-1:0] res_velocity;
    logic signed [COEFF_W-1:0] res_acceleration;
    logic                res_saturated;
    logic                res_stall = 1'b0;
    logic                cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEFF_W-1:0]  cfg_data;

    int                  error_count;
    int                  pending;
    int                  cycle_cnt = 0;
    int                  hold_left = 0;
    logic                result_taken = 1'b0;
    bit                  calm = 1'b0;
    t_coef_style         style;

    always #1 clk = ~clk;

    quintic_trajectory_evaluator_unit i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .i_time_point   (req_time),
        .o_stall        (req_stall),
        .o_valid        (res_valid),
        .o_position     (res_position),
        .o_velocity     (res_velocity),
        .o_acceleration (res_acceleration),
        .o_saturated    (res_saturated),
        .i_stall        (res_stall),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    quintic_trajectory_checker u_motion_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_stall    (req_stall),
        .i_time_point   (req_time),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_position     (res_position),
        .i_velocity     (res_velocity),
        .i_acceleration (res_acceleration),
        .i_saturated    (res_saturated),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_error_count  (error_count),
        .o_pending      (pending)
    );

    // Result side: after each accepted result, hold stall for a random number of cycles.
    always @(posedge clk) begin
        result_taken <= res_valid && !res_stall;
    end

    always @(negedge clk) begin
        if (result_taken) begin
            hold_left = calm ? 0 : $urandom_range(0, 7);
        end
        if (hold_left > 0) begin
            res_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            res_stall <= 1'b0;
        end
    end

    // Give up on a run that stops making progress.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit.");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one request after a random gap and wait until it is accepted.
    task automatic send_time(input logic [TIME_W-1:0] t);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_time  <= t;
        do @(posedge clk); while (req_stall);
    endtask

    // Drop the request line, then wait until every prediction has been matched.
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_coeffs(input logic [COEFF_W-1:0] c0, input logic [COEFF_W-1:0] c1,
                              input logic [COEFF_W-1:0] c2, input logic [COEFF_W-1:0] c3,
                              input logic [COEFF_W-1:0] c4, input logic [COEFF_W-1:0] c5);
        write_reg(REG_COEFF_0, c0);
        write_reg(REG_COEFF_1, c1);
        write_reg(REG_COEFF_2, c2);
        write_reg(REG_COEFF_3, c3);
        write_reg(REG_COEFF_4, c4);
        write_reg(REG_COEFF_5, c5);
    endtask

    function automatic logic [COEFF_W-1:0] draw_coeff(input t_coef_style s);
        t_coef_style pick;
        pick = (s == COEF_MIXED) ? t_coef_style'($urandom_range(0, 2)) : s;
        case (pick)
            COEF_FULL: begin
                return $urandom;
            end
            // Within about +/-16.0, so most results stay inside the output range.
            COEF_SMALL: begin
                return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return '0;
                    3: return '1;
                    default: return WORD_ONE;
                endcase
            end
        endcase
    endfunction

    // Mostly short times, some past the clip point, some near it, a few anywhere in the range.
    function automatic logic [TIME_W-1:0] draw_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return TIME_W'($urandom_range(0, 24'h01_FFFF));
        end else if (r < 8) begin
            return TIME_W'($urandom_range(0, 24'h0B_FFFF));
        end else if (r == 8) begin
            return TIME_W'($urandom_range(T_CLIP_EDGE - 1024, T_CLIP_EDGE + 1024));
        end
        return TIME_W'($urandom);
    endfunction

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_time  = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_COEFF_0;
        cfg_data  = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Coefficients are zero after reset; the largest time still clips the powers.
        send_time('0);
        send_time(T_MAX);
        settle();

        // A known curve, with writes past the last coefficient that must change nothing.
        set_coeffs(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000,
                   32'h0000_8000, 32'hFFFF_C000, 32'h0000_2000);
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, WORD_MAX);
        foreach (SHAPE_TIMES[n]) send_time(SHAPE_TIMES[n]);
        settle();

        // Largest positive coefficients.
        set_coeffs(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send_time(24'h00_0001);
        send_time(T_ONE);
        send_time(T_CLIP_EDGE - 1);
        send_time(T_MAX);
        settle();

        // Most negative coefficients.
        set_coeffs(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_time(24'h00_0001);
        send_time(T_ONE);
        send_time(T_CLIP_EDGE - 1);
        send_time(T_MAX);
        settle();

        // Random phases: fresh coefficients, then a stream of random time points.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            calm  = ($urandom_range(0, 3) == 0);
            style = t_coef_style'($urandom_range(0, 3));
            set_coeffs(draw_coeff(style), draw_coeff(style), draw_coeff(style),
                       draw_coeff(style), draw_coeff(style), draw_coeff(style));
            if ($urandom_range(0, 2) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_time(draw_time());
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
